// ===== rtl/strongly_connected_components_top_assert.svh =====
// Assertion macros for the strongly connected components block.
`ifndef STRONGLY_CONNECTED_COMPONENTS_TOP_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SCC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SCC_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCC_ASSERT(label, clk, rstn, prop, msg)
`define SCC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/scc_pkg.sv =====
// Shared constants and types for the strongly connected components block.
package scc_pkg;
    localparam int MaxVertices = 32;
    localparam int MaxEdges    = 128;
    localparam int VW = $clog2(MaxVertices);
    localparam int EW = $clog2(MaxEdges);
    localparam int CW = EW + 1;
    localparam int SW = $clog2(MaxVertices);

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [0:0] REG_VCOUNT = 1'd0;
    localparam logic [0:0] REG_ECOUNT = 1'd1;

    typedef struct packed {
        logic [2:0]    status;
        logic [VW-1:0] component;
        logic [VW-1:0] vertex;
        logic          last;
    } result_t;
endpackage

// ===== rtl/strongly_connected_components_top.sv =====
// Top level: edge table memory, Kosaraju sequencer and stream/APB ports.
// Add, clear and invalid compute answer directly; remove scans the edge table and shifts
//   later entries down; compute walks the edge table in two depth-first passes.
// One item at a time; the next is accepted once all results are queued out.
// Reset (aresetn, synchronous, active low) clears state, counts, visited flags, stack pointer
//   and output flags; other datapath registers and memories are not cleared.
`include "strongly_connected_components_top_assert.svh"
module strongly_connected_components_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[1:0], from_vertex[6:2], to_vertex[11:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[2:0], component[7:3], vertex[12:8]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scc_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RMRD  = 5'd1;
    localparam logic [4:0] S_RMCHK = 5'd2;
    localparam logic [4:0] S_SHRD  = 5'd3;
    localparam logic [4:0] S_SHWR  = 5'd4;
    localparam logic [4:0] S_P1INIT = 5'd5;
    localparam logic [4:0] S_ROOT  = 5'd6;
    localparam logic [4:0] S_TOP   = 5'd7;
    localparam logic [4:0] S_SCAN  = 5'd8;
    localparam logic [4:0] S_CHK   = 5'd9;
    localparam logic [4:0] S_VIS   = 5'd10;
    localparam logic [4:0] S_FORD  = 5'd11;
    localparam logic [4:0] S_FOCHK = 5'd12;
    localparam logic [4:0] S_EMIT  = 5'd13;
    localparam logic [4:0] S_DONE  = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;

    logic [5:0] vcount_reg;
    logic [7:0] ecount_reg;
    logic [CW-1:0] stored_reg;

    // edge table memory
    logic [2*VW-1:0] emem [MaxEdges];
    logic [2*VW-1:0] erd_reg;
    logic [EW-1:0] eaddr;
    logic          ewe;
    logic [2*VW-1:0] ewd;
    always_ff @(posedge aclk) begin
        if (ewe) emem[eaddr] <= ewd;
        erd_reg <= emem[eaddr];
    end

    // finish order memory
    logic [VW-1:0] fmem [MaxVertices];
    logic [VW-1:0] frd_reg;
    logic [VW-1:0] faddr;
    logic          fwe;
    logic [VW-1:0] fwd;
    always_ff @(posedge aclk) begin
        if (fwe) fmem[faddr] <= fwd;
        frd_reg <= fmem[faddr];
    end

    // stack memory: vertex and cursor
    logic [VW+CW-1:0] kmem [MaxVertices];
    logic [VW+CW-1:0] krd_reg;
    logic [SW-1:0] kaddr;
    logic          kwe;
    logic [VW+CW-1:0] kwd;
    always_ff @(posedge aclk) begin
        if (kwe) kmem[kaddr] <= kwd;
        krd_reg <= kmem[kaddr];
    end

    logic [4:0]    state_reg, state_next;
    logic [MaxVertices-1:0] vis_reg, vis_next;
    logic [VW-1:0] fv_reg, fv_next, tv_reg, tv_next;
    logic [CW-1:0] e_reg, e_next;
    logic [VW:0]   sp_reg, sp_next;
    logic [VW:0]   fin_reg, fin_next;
    logic [VW:0]   root_reg, root_next;
    logic [VW-1:0] u_reg, u_next, w_reg, w_next;
    logic [VW-1:0] comp_reg, comp_next;
    logic          pass2_reg, pass2_next;
    logic [CW-1:0] stored_next;

    // output skid: one result register
    logic    ov_reg, ov_next;
    result_t ores_reg, ores_next;

    logic    push;
    result_t pres;
    logic    can_push;
    assign can_push = !ov_reg || m_tready;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_VCOUNT: prdata = {26'd0, vcount_reg};
            REG_ECOUNT: prdata = {24'd0, ecount_reg};
            default:    prdata = '0;
        endcase
    end

    logic in_acc;
    assign s_tready = (state_reg == S_IDLE) && can_push;
    assign in_acc = s_tvalid && s_tready;

    logic [VW-1:0] es, et;
    assign es = erd_reg[2*VW-1:VW];
    assign et = erd_reg[VW-1:0];
    logic [6:0] n_ext;
    assign n_ext = {1'b0, vcount_reg};

    always_comb begin
        state_next = state_reg; vis_next = vis_reg;
        fv_next = fv_reg; tv_next = tv_reg; e_next = e_reg; sp_next = sp_reg;
        fin_next = fin_reg; root_next = root_reg; u_next = u_reg; w_next = w_reg;
        comp_next = comp_reg; pass2_next = pass2_reg; stored_next = stored_reg;
        eaddr = e_reg[EW-1:0]; ewe = 1'b0; ewd = erd_reg;
        faddr = '0; fwe = 1'b0; fwd = u_reg;
        kaddr = '0; kwe = 1'b0; kwd = '0;
        push = 1'b0; pres = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    fv_next = s_tdata[6:2];
                    tv_next = s_tdata[11:7];
                    if (s_tdata[1:0] == OP_COMPUTE) begin
                        if (vcount_reg == 6'd0 || ecount_reg == 8'd0 ||
                            {1'b0, ecount_reg} > {2'b0, vcount_reg, 1'b0} ||
                            n_ext > 7'(MaxVertices)) begin
                            push = 1'b1; pres.status = ST_INVALID; pres.last = 1'b1;
                        end else begin
                            vis_next = '0; fin_next = '0; root_next = '0;
                            pass2_next = 1'b0; comp_next = '0;
                            state_next = S_ROOT;
                        end
                    end else if (s_tdata[1:0] == OP_CLEAR) begin
                        stored_next = '0;
                        push = 1'b1; pres.last = 1'b1;
                    end else if ({2'b0, s_tdata[6:2]} >= n_ext ||
                                 {2'b0, s_tdata[11:7]} >= n_ext) begin
                        push = 1'b1; pres.status = ST_RANGE; pres.last = 1'b1;
                    end else if (s_tdata[1:0] == OP_ADD) begin
                        if (stored_reg >= CW'(MaxEdges)) begin
                            push = 1'b1; pres.status = ST_FULL; pres.last = 1'b1;
                        end else begin
                            eaddr = stored_reg[EW-1:0]; ewe = 1'b1;
                            ewd = {s_tdata[6:2], s_tdata[11:7]};
                            stored_next = stored_reg + 1'b1;
                            push = 1'b1; pres.last = 1'b1;
                        end
                    end else begin
                        e_next = '0; eaddr = '0; state_next = S_RMRD;
                    end
                end
            end
            S_RMRD: begin
                if (e_reg >= stored_reg) begin
                    state_next = S_FIN;
                    w_next = '0; u_next = {2'b0, ST_NOTFOUND};
                end else begin
                    eaddr = e_reg[EW-1:0]; state_next = S_RMCHK;
                end
            end
            S_RMCHK: begin
                if (es == fv_reg && et == tv_reg) begin
                    state_next = S_SHRD;
                end else begin
                    e_next = e_reg + 1'b1; eaddr = e_next[EW-1:0]; state_next = S_RMRD;
                end
            end
            S_SHRD: begin
                if (e_reg + 1'b1 >= stored_reg) begin
                    stored_next = stored_reg - 1'b1;
                    state_next = S_FIN; u_next = {2'b0, ST_OK};
                end else begin
                    eaddr = e_reg[EW-1:0] + 1'b1; state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                eaddr = e_reg[EW-1:0]; ewe = 1'b1; ewd = erd_reg;
                e_next = e_reg + 1'b1; state_next = S_SHRD;
            end
            S_FIN: begin
                if (can_push) begin
                    push = 1'b1; pres.status = u_reg[2:0]; pres.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_P1INIT: begin
                // start pass two: walk finish order backwards
                vis_next = '0; pass2_next = 1'b1; root_next = fin_reg;
                state_next = S_FORD;
            end
            S_ROOT: begin
                if (root_reg >= {1'b0, vcount_reg[VW-1:0]} && vcount_reg != 6'd32) begin
                    state_next = S_P1INIT;
                end else if (root_reg[VW] && !pass2_reg) begin
                    state_next = S_P1INIT;
                end else if (vis_reg[root_reg[VW-1:0]]) begin
                    root_next = root_reg + 1'b1;
                end else begin
                    w_next = root_reg[VW-1:0]; sp_next = '0; state_next = S_VIS;
                end
            end
            S_FORD: begin
                if (root_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    faddr = root_reg[VW-1:0] - 1'b1; state_next = S_FOCHK;
                end
            end
            S_FOCHK: begin
                root_next = root_reg - 1'b1;
                if ({2'b0, frd_reg} < n_ext && !vis_reg[frd_reg]) begin
                    w_next = frd_reg; sp_next = '0; state_next = S_VIS;
                end else begin
                    state_next = S_FORD;
                end
            end
            S_VIS: begin
                // mark w, report in pass two, push it with cursor zero
                if (!pass2_reg || can_push) begin
                    vis_next[w_reg] = 1'b1;
                    if (pass2_reg) begin
                        push = 1'b1; pres.component = comp_reg; pres.vertex = w_reg;
                    end
                    kaddr = sp_reg[SW-1:0]; kwe = 1'b1; kwd = {w_reg, {CW{1'b0}}};
                    sp_next = sp_reg + 1'b1;
                    state_next = S_TOP;
                end
            end
            S_TOP: begin
                if (sp_reg == '0) begin
                    if (pass2_reg) begin
                        comp_next = comp_reg + 1'b1; state_next = S_FORD;
                    end else begin
                        root_next = root_reg + 1'b1; state_next = S_ROOT;
                    end
                end else begin
                    kaddr = sp_reg[SW-1:0] - 1'b1; state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                u_next = krd_reg[VW+CW-1:CW]; e_next = krd_reg[CW-1:0];
                eaddr = krd_reg[EW-1:0]; state_next = S_SCAN;
            end
            S_SCAN: begin
                if (e_reg >= stored_reg) begin
                    sp_next = sp_reg - 1'b1;
                    if (!pass2_reg && !fin_reg[VW]) begin
                        faddr = fin_reg[VW-1:0]; fwe = 1'b1; fwd = u_reg;
                        fin_next = fin_reg + 1'b1;
                    end
                    state_next = S_TOP;
                end else begin
                    eaddr = e_reg[EW-1:0]; state_next = S_CHK;
                end
            end
            S_CHK: begin
                e_next = e_reg + 1'b1;
                eaddr = e_next[EW-1:0];
                state_next = S_SCAN;
                if ({2'b0, es} < n_ext && {2'b0, et} < n_ext &&
                    ((!pass2_reg && es == u_reg) || (pass2_reg && et == u_reg))) begin
                    kaddr = sp_reg[SW-1:0] - 1'b1; kwe = 1'b1; kwd = {u_reg, e_next};
                    w_next = pass2_reg ? es : et;
                    if (!vis_reg[pass2_reg ? es : et] && !sp_reg[VW])
                        state_next = S_VIS;
                    else
                        state_next = S_TOP;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // last flag: the final pass-two report is known only at the end, so hold
    // the newest report and release it as last in S_DONE
    logic    held_reg, held_next;
    result_t hres_reg, hres_next;
    always_comb begin
        ov_next = ov_reg && !m_tready; ores_next = ores_reg;
        held_next = held_reg; hres_next = hres_reg;
        if (push && pass2_reg && state_reg == S_VIS) begin
            if (held_reg) begin
                ov_next = 1'b1; ores_next = hres_reg;
            end
            held_next = 1'b1; hres_next = pres;
        end else if (push) begin
            ov_next = 1'b1; ores_next = pres;
        end else if (state_reg == S_DONE && held_reg && can_push) begin
            ov_next = 1'b1; ores_next = hres_reg; ores_next.last = 1'b1;
            held_next = 1'b0;
        end
    end

    logic [4:0] st_fix;
    assign st_fix = (state_reg == S_DONE && held_reg && !can_push) ? S_DONE : state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; vcount_reg <= '0; ecount_reg <= '0;
            stored_reg <= '0; ov_reg <= 1'b0; held_reg <= 1'b0; vis_reg <= '0;
            pass2_reg <= 1'b0; sp_reg <= '0;
        end else begin
            state_reg <= st_fix; stored_reg <= stored_next; ov_reg <= ov_next;
            held_reg <= held_next; vis_reg <= vis_next; pass2_reg <= pass2_next;
            sp_reg <= sp_next;
            if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == REG_VCOUNT)
                vcount_reg <= pwdata[5:0];
            if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == REG_ECOUNT)
                ecount_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        fv_reg <= fv_next; tv_reg <= tv_next; e_reg <= e_next;
        fin_reg <= fin_next; root_reg <= root_next;
        u_reg <= u_next; w_reg <= w_next; comp_reg <= comp_next;
        ores_reg <= ores_next; hres_reg <= hres_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'd0, ores_reg.vertex, ores_reg.component, ores_reg.status};
    assign m_tlast  = ores_reg.last;

    `SCC_ASSERT(a_ready_idle, aclk, aresetn, s_tready |-> state_reg == S_IDLE, "ready outside idle")
    `SCC_ASSERT(a_stack_bound, aclk, aresetn, sp_reg <= (VW+1)'(MaxVertices), "stack overflow")
    `SCC_ASSERT(a_stored_bound, aclk, aresetn, stored_reg <= CW'(MaxEdges), "edge count overflow")
endmodule
